// File: hdl/ans_pkg.sv
// ----------------------------------------------------------------------------
// ans_pkg
// Types and constants shared by the nonce session table modules.
// ----------------------------------------------------------------------------
package ans_pkg;

  // default table size and reset values
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam logic [15:0] ISSUE_COUNT_RESET = 16'hCA53;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd300;

  typedef enum logic {
    CMD_START    = 1'b0,
    CMD_VALIDATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_ISSUED   = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ACCEPTED = 2'd2,
    STAT_REJECTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_VAL,
    ST_RESULT
  } state_t;

  // request word
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] now_time;
    logic [31:0] random_nonce;
    logic [31:0] random_opaque;
    logic [31:0] given_nonce_time;
    logic [15:0] given_nonce_count;
    logic [31:0] given_nonce_random;
    logic [31:0] given_opaque;
    logic        realm_ok;
    logic        fields_present;
  } req_t;

  // response word
  typedef struct packed {
    status_t     status;
    logic [31:0] nonce_time;
    logic [15:0] nonce_count;
    logic [31:0] nonce_random;
    logic [31:0] opaque_out;
  } rsp_t;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] count;
    logic [31:0] nonce_random;
    logic [31:0] opaque;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

// File: hdl/ans_stream_if.sv
// ----------------------------------------------------------------------------
// ans_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface ans_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ans_ram.sv
// ----------------------------------------------------------------------------
// ans_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ans_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ans_ctrl.sv
// ----------------------------------------------------------------------------
// ans_ctrl
// Command sequencer: slot allocation, validate scan over the slot memory,
// slot valid bits and issue counter.
// ----------------------------------------------------------------------------
module ans_ctrl #(
  parameter int unsigned TABLE_ENTRIES = ans_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  ans_pkg::req_t        item,
  input  logic [15:0]          timeout_seconds,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ans_pkg::rsp_t        res,
  output logic                 mem_we,
  output logic [IDX_W-1:0]     mem_waddr,
  output ans_pkg::slot_t       mem_wdata,
  output logic                 mem_re,
  output logic [IDX_W-1:0]     mem_raddr,
  input  ans_pkg::slot_t       mem_rdata
);
  import ans_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t                   state, state_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic [TABLE_ENTRIES-1:0] slot_valid, slot_valid_next;
  logic [15:0]              issue_count, issue_count_next;
  req_t                     item_q;
  rsp_t                     res_next;
  logic                     expired;
  logic                     match;

  // expiry: stamp plus timeout, 33 bits, below current time
  assign expired = ({1'b0, mem_rdata.stamp} + {17'b0, timeout_seconds})
                   < {1'b0, item_q.now_time};

  assign match = item_q.realm_ok
              && (mem_rdata.stamp        == item_q.given_nonce_time)
              && (mem_rdata.count        == item_q.given_nonce_count)
              && (mem_rdata.nonce_random == item_q.given_nonce_random)
              && (mem_rdata.opaque       == item_q.given_opaque);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      slot_valid  <= '0;
      issue_count <= ISSUE_COUNT_RESET;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      slot_valid  <= slot_valid_next;
      issue_count <= issue_count_next;
    end
  end

  // captured request and pending result
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
    res <= res_next;
  end

  // next state and memory accesses
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    slot_valid_next  = slot_valid;
    issue_count_next = issue_count;
    res_next         = res;
    item_ready       = (state == ST_IDLE);
    res_valid        = (state == ST_RESULT);
    mem_we           = 1'b0;
    mem_waddr        = idx;
    mem_wdata        = '{stamp: item_q.now_time, count: issue_count,
                         nonce_random: item_q.random_nonce,
                         opaque: item_q.random_opaque};
    mem_re           = 1'b0;
    mem_raddr        = '0;

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          idx_next = '0;
          if (item.cmd == CMD_START) begin
            state_next = ST_START;
          end else if (!item.fields_present) begin
            res_next   = '{status: STAT_REJECTED, default: '0};
            state_next = ST_RESULT;
          end else begin
            mem_re     = 1'b1;
            state_next = ST_VAL;
          end
        end
      end

      // walk the valid bits for the lowest free slot
      ST_START: begin
        if (!slot_valid[idx]) begin
          mem_we               = 1'b1;
          slot_valid_next[idx] = 1'b1;
          issue_count_next     = issue_count + 16'd1;
          res_next = '{status: STAT_ISSUED, nonce_time: item_q.now_time,
                       nonce_count: issue_count,
                       nonce_random: item_q.random_nonce,
                       opaque_out: item_q.random_opaque};
          state_next = ST_RESULT;
        end else if (idx == LAST_IDX) begin
          res_next   = '{status: STAT_FULL, default: '0};
          state_next = ST_RESULT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      // data for slot idx is here; the read of idx+1 goes out meanwhile
      ST_VAL: begin
        if (slot_valid[idx] && !expired && match) begin
          slot_valid_next[idx] = 1'b0;
          res_next   = '{status: STAT_ACCEPTED, default: '0};
          state_next = ST_RESULT;
        end else begin
          if (slot_valid[idx] && expired) begin
            slot_valid_next[idx] = 1'b0;
          end
          if (idx == LAST_IDX) begin
            res_next   = '{status: STAT_REJECTED, default: '0};
            state_next = ST_RESULT;
          end else begin
            idx_next  = idx + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = idx + 1'b1;
          end
        end
      end

      ST_RESULT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/auth_nonce_session_table_core.sv
// ----------------------------------------------------------------------------
// auth_nonce_session_table_core
// Table of one-time authentication nonces with start and validate commands.
// ----------------------------------------------------------------------------
// usage
//   req: request words (start or validate) on a valid/ready channel
//   rsp: one response word per request, held in an output register
//   cfg_wr_en / cfg_wr_data: write of timeout_seconds, only while idle
// timing
//   one request at a time; the slot memory is scanned one slot per cycle
//   start: walks the valid bits from slot 0 to the lowest free slot
//   (table full: STAT_FULL once the last slot is taken)
//   validate: scans up to TABLE_ENTRIES slots, stopping early on a match;
//   missing fields give a result without any scan
//   the scan pace is set by the single read port of the slot memory
// reset
//   all slots free, issue counter 0xCA53, timeout 300, no response pending
// stall
//   a waiting response sits in the output register; the next request is
//   taken meanwhile and its result waits until the register frees up
// ----------------------------------------------------------------------------
module auth_nonce_session_table_core #(
  parameter int unsigned TABLE_ENTRIES = ans_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ans_stream_if.sink         req,
  ans_stream_if.source       rsp,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);
  import ans_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [15:0]      timeout_seconds;
  logic             item_ready;
  logic             res_valid;
  logic             res_ready;
  rsp_t             res;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  slot_t            mem_rdata;
  logic             out_valid;
  rsp_t             out_data;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_seconds <= cfg_wr_data;
    end
  end

  ans_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (req.valid),
    .item_ready      (item_ready),
    .item            (req.data),
    .timeout_seconds (timeout_seconds),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  ans_ram #(
    .WIDTH  (SLOT_W),
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready = item_ready;

  // output register
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

`ifndef ASSERT_OFF
  // one request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while previous one in progress");

  // only an issued nonce carries payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.data.status != STAT_ISSUED) |->
      (rsp.data.nonce_time == 32'd0) && (rsp.data.nonce_count == 16'd0)
      && (rsp.data.nonce_random == 32'd0) && (rsp.data.opaque_out == 32'd0))
    else $error("non-issue response with nonzero payload");

  // a result held back by a full output register stays put
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed while stalled");
`endif

endmodule

// File: verif/auth_nonce_session_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// auth_nonce_session_table_core_tb
// Self-checking bench for the nonce session table. A queue of request words
// feeds a valid/ready driver, and a table model predicts each reply when its
// request is taken. A monitor compares every reply word field by field. The
// timeout register is set to several values, the extremes among them, and
// both channels idle at random.
// ----------------------------------------------------------------------------
module auth_nonce_session_table_core_tb;
  import ans_pkg::*;

  localparam int unsigned NSLOT     = TABLE_ENTRIES_DEF;
  localparam int          CYC_LIMIT = 400000;

  // table contents as the model keeps them
  typedef struct packed {
    logic [NSLOT-1:0] vld;
    slot_t [NSLOT-1:0] ent;
    logic [15:0]      issue_cnt;
    logic [15:0]      tmo;
  } nonce_table_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        drv_valid = 1'b0;
  req_t        drv_req = '0;
  logic        drv_ready = 1'b0;
  logic        cfg_en = 1'b0;
  logic [15:0] cfg_data = '0;

  int          cyc = 0;
  int          fail_count = 0;
  logic [31:0] gen_now = '0;

  nonce_table_t live_tbl;
  nonce_table_t plan_tbl;
  req_t         req_words[$];
  rsp_t         table_replies[$];
  slot_t        issued_nonces[$];

  ans_stream_if #(.payload_t(req_t)) req_ch ();
  ans_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  assign req_ch.valid = drv_valid;
  assign req_ch.data  = drv_req;
  assign rsp_ch.ready = drv_ready;

  auth_nonce_session_table_core #(.TABLE_ENTRIES(NSLOT)) dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_en),
    .cfg_wr_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic nonce_table_t fresh_table();
    nonce_table_t t;
    t = '0;
    t.issue_cnt = ISSUE_COUNT_RESET;
    t.tmo = TIMEOUT_RESET;
    return t;
  endfunction

  // one request word applied to a table, giving its reply word
  function automatic rsp_t nonce_table_step(inout nonce_table_t t, input req_t r);
    rsp_t        o;
    logic        done;
    logic [32:0] deadline;
    o = '0;
    done = 1'b0;
    if (r.cmd == CMD_START) begin
      o.status = STAT_FULL;
      for (int i = 0; i < NSLOT; i++) begin
        if (!done && !t.vld[i]) begin
          t.vld[i] = 1'b1;
          t.ent[i] = {r.now_time, t.issue_cnt, r.random_nonce, r.random_opaque};
          o.status = STAT_ISSUED;
          o.nonce_time = r.now_time;
          o.nonce_count = t.issue_cnt;
          o.nonce_random = r.random_nonce;
          o.opaque_out = r.random_opaque;
          t.issue_cnt = t.issue_cnt + 16'd1;
          done = 1'b1;
        end
      end
    end else begin
      o.status = STAT_REJECTED;
      // missing fields: no scan at all
      if (r.fields_present) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!done && t.vld[i]) begin
            deadline = {1'b0, t.ent[i].stamp} + {17'd0, t.tmo};
            if (deadline < {1'b0, r.now_time}) begin
              t.vld[i] = 1'b0;
            end else if (r.realm_ok && t.ent[i] == {r.given_nonce_time, r.given_nonce_count,
                                                     r.given_nonce_random, r.given_opaque}) begin
              t.vld[i] = 1'b0;
              o.status = STAT_ACCEPTED;
              done = 1'b1;
            end
          end
        end
      end
    end
    return o;
  endfunction

  function automatic logic idle_on();
    return !(cyc >= 4000 && cyc < 9000);
  endfunction

  function automatic req_t noise_word();
    req_t r;
    r.cmd = cmd_t'($urandom_range(0, 1));
    r.now_time = $urandom;
    r.random_nonce = $urandom;
    r.random_opaque = $urandom;
    r.given_nonce_time = $urandom;
    r.given_nonce_count = 16'($urandom);
    r.given_nonce_random = $urandom;
    r.given_opaque = $urandom;
    r.realm_ok = 1'($urandom);
    r.fields_present = 1'($urandom);
    return r;
  endfunction

  function automatic req_t present_word(slot_t h, logic [31:0] now, logic realm, logic present);
    req_t r;
    r = noise_word();
    r.cmd = CMD_VALIDATE;
    r.now_time = now;
    r.given_nonce_time = h.stamp;
    r.given_nonce_count = h.count;
    r.given_nonce_random = h.nonce_random;
    r.given_opaque = h.opaque;
    r.realm_ok = realm;
    r.fields_present = present;
    return r;
  endfunction

  function automatic req_t start_word(logic [31:0] now, logic [31:0] rn, logic [31:0] ro);
    req_t r;
    r = noise_word();
    r.cmd = CMD_START;
    r.now_time = now;
    r.random_nonce = rn;
    r.random_opaque = ro;
    return r;
  endfunction

  // start words, and replays of recently issued nonces, some corrupted, some noise
  function automatic req_t make_word(int pct_val, int step_max);
    req_t  r;
    slot_t h;
    int    depth;
    if ($urandom_range(0, 49) == 0) gen_now = $urandom;
    else gen_now = gen_now + 32'($urandom_range(0, step_max));
    if ($urandom_range(0, 99) >= pct_val) begin
      return start_word(gen_now, $urandom, $urandom);
    end
    if (issued_nonces.size() == 0 || $urandom_range(0, 99) < 12) begin
      r = noise_word();
      r.cmd = CMD_VALIDATE;
      r.now_time = gen_now;
      return r;
    end
    depth = issued_nonces.size() < 20 ? issued_nonces.size() : 20;
    h = issued_nonces[issued_nonces.size() - 1 - $urandom_range(0, depth - 1)];
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0: h.stamp = h.stamp ^ (32'd1 << $urandom_range(0, 31));
        1: h.count = h.count ^ (16'd1 << $urandom_range(0, 15));
        2: h.nonce_random = h.nonce_random ^ (32'd1 << $urandom_range(0, 31));
        default: h.opaque = h.opaque ^ (32'd1 << $urandom_range(0, 31));
      endcase
    end
    return present_word(h, gen_now, $urandom_range(0, 9) != 0, $urandom_range(0, 11) != 0);
  endfunction

  // queue a request word, tracking the nonces it will issue
  task automatic push_word(req_t r);
    rsp_t  p;
    slot_t s;
    p = nonce_table_step(plan_tbl, r);
    if (p.status == STAT_ISSUED) begin
      s.stamp = p.nonce_time;
      s.count = p.nonce_count;
      s.nonce_random = p.nonce_random;
      s.opaque = p.opaque_out;
      issued_nonces.push_back(s);
      if (issued_nonces.size() > 64) void'(issued_nonces.pop_front());
    end
    req_words.push_back(r);
  endtask

  // wait until no word is queued, in flight or owed
  task automatic wait_idle();
    while (req_words.size() != 0 || drv_valid || table_replies.size() != 0) @(negedge clk);
    repeat (NSLOT + 4) @(negedge clk);
  endtask

  task automatic set_timeout(logic [15:0] v);
    wait_idle();
    @(posedge clk);
    cfg_en <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_en <= 1'b0;
    plan_tbl.tmo = v;
    live_tbl.tmo = v;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [15:0] tmo, int step_max, int pct_val,
                           logic [31:0] start_now, int n);
    set_timeout(tmo);
    gen_now = start_now;
    for (int i = 0; i < n; i++) push_word(make_word(pct_val, step_max));
    wait_idle();
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // request driver: takes words from the queue, predicts on accept
  always @(posedge clk) begin : req_drive
    rsp_t e;
    if (rst) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && req_ch.ready) begin
        e = nonce_table_step(live_tbl, drv_req);
        table_replies.push_back(e);
      end
      if (!drv_valid || req_ch.ready) begin
        if (req_words.size() != 0 && !(idle_on() && $urandom_range(0, 99) < 20)) begin
          drv_req <= req_words.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor with random back-pressure
  always @(posedge clk) begin : rsp_watch
    rsp_t e;
    rsp_t a;
    if (rst) begin
      drv_ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        a = rsp_ch.data;
        if (table_replies.size() == 0) begin
          $error("reply word with none owed: status %0d", a.status);
          fail_count++;
        end else begin
          e = table_replies.pop_front();
          cmp_field("status", 32'(e.status), 32'(a.status));
          cmp_field("nonce_time", e.nonce_time, a.nonce_time);
          cmp_field("nonce_count", 32'(e.nonce_count), 32'(a.nonce_count));
          cmp_field("nonce_random", e.nonce_random, a.nonce_random);
          cmp_field("opaque_out", e.opaque_out, a.opaque_out);
        end
      end
      drv_ready <= !(idle_on() && $urandom_range(0, 99) < 20);
    end
  end

  // run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    slot_t h;
    live_tbl = fresh_table();
    plan_tbl = fresh_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, extreme values, realm and field cases, replay
    push_word(present_word('0, 32'd0, 1'b1, 1'b1));
    push_word(start_word(32'd0, 32'd0, 32'd0));
    push_word(start_word(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    h = issued_nonces[issued_nonces.size() - 1];
    // realm mismatch still frees the stale zero-stamp slot
    push_word(present_word(h, 32'hFFFF_FFFF, 1'b0, 1'b1));
    push_word(present_word(h, 32'hFFFF_FFFF, 1'b1, 1'b0));
    // stamp plus timeout passes 32 bits: still usable
    push_word(present_word(h, 32'hFFFF_FFFF, 1'b1, 1'b1));
    push_word(present_word(h, 32'hFFFF_FFFF, 1'b1, 1'b1));
    // fill the table, then one more start for the full case
    for (int i = 0; i <= NSLOT; i++) push_word(start_word(32'd1000 + i, $urandom, $urandom));
    h = issued_nonces[issued_nonces.size() - NSLOT + 5];
    push_word(present_word(h, 32'd1100, 1'b1, 1'b1));
    push_word(start_word(32'd1101, $urandom, $urandom));
    wait_idle();

    // random phases over several timeout settings
    run_phase(16'd0, 2, 55, 32'h0000_0100, 290);
    run_phase(16'hFFFF, 9000, 50, 32'hFFFF_0000, 290);
    run_phase(16'd1, 2, 45, $urandom, 290);
    run_phase(16'd300, 40, 50, $urandom, 290);
    begin : rand_tmo
      logic [15:0] t;
      t = 16'($urandom_range(2, 2000));
      run_phase(t, t / 6 + 2, 60, $urandom, 290);
    end
    run_phase(16'd300, 30, 35, $urandom, 290);

    repeat (NSLOT + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
